// ===== rtl/swmm_pkg.sv =====
// Shared constants for the sliding window max/min block.
`default_nettype none
package swmm_pkg;

	localparam int WINDOW_MAX_DEF   = 256;
	localparam int SAMPLE_WIDTH_DEF = 32;

	// Configuration port: widest register is window_length.
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SELECT_MIN    = 1'd1;

endpackage
`default_nettype wire

// ===== rtl/swmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module swmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/sliding_window_max_min.sv =====
// Sliding window maximum/minimum over a signed sample series, monotonic queue in RAM.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    sample, series_start
//   output    out        out_valid / out_ready  extreme
//   config    in         cfg_we                 cfg_index, cfg_data
//
// One word at a time. Each queue entry examined, namely each expired head, each dominated tail
// and the entries that stop the scans, takes a RAM address step, then a compare step; a scan
// that finds the queue empty takes only its address step, and the push step raises out_valid,
// so an empty queue goes from acceptance through head read, tail read and push.
// in_ready is high only while the sequencer is idle; a result waiting on out_ready holds the
// sequencer in its push step. Reset empties the queue; RAM contents need no clearing.
`default_nettype none
module sliding_window_max_min #(
	parameter int WINDOW_MAX   = swmm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0]     sample,
	input  wire logic                               series_start,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed      [SAMPLE_WIDTH-1:0]     extreme,
	input  wire logic                               cfg_we,
	input  wire logic        [swmm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [swmm_pkg::CFG_W-1:0]  cfg_data
);
	import swmm_pkg::*;

	localparam int POS_W  = $clog2(2 * WINDOW_MAX);
	localparam int ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
	localparam int CMP_W  = (POS_W > CFG_W) ? POS_W : CFG_W;
	localparam int RAM_W  = POS_W + SAMPLE_WIDTH;

	localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW_MAX - 1);
	localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(2 * WINDOW_MAX - 1);
	localparam logic [POS_W:0]    POS_MOD   = (POS_W + 1)'(2 * WINDOW_MAX);
	localparam logic [CMP_W-1:0]  W_LIMIT   = CMP_W'(WINDOW_MAX);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_HEAD_RD  = 3'd1;
	localparam logic [2:0] ST_HEAD_CHK = 3'd2;
	localparam logic [2:0] ST_TAIL_RD  = 3'd3;
	localparam logic [2:0] ST_TAIL_CHK = 3'd4;
	localparam logic [2:0] ST_PUSH     = 3'd5;

	logic [2:0]                     state_q;
	logic [CFG_W-1:0]               window_length_q;
	logic                           select_min_q;
	logic [ADDR_W-1:0]              head_q;
	logic [ADDR_W-1:0]              tail_q;
	logic [CNT_W-1:0]               count_q;
	logic [POS_W-1:0]               pos_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic signed [SAMPLE_WIDTH-1:0] head_val_q;
	logic signed [SAMPLE_WIDTH-1:0] extreme_q;
	logic                           out_valid_q;

	logic [ADDR_W-1:0]              head_next;
	logic [ADDR_W-1:0]              tail_next;
	logic [ADDR_W-1:0]              tail_prev;
	logic [POS_W-1:0]               pos_next;
	logic [CMP_W-1:0]               w_raw;
	logic [CMP_W-1:0]               w_eff;
	logic [RAM_W-1:0]               ram_rdata;
	logic [ADDR_W-1:0]              ram_raddr;
	logic                           ram_we;
	logic signed [SAMPLE_WIDTH-1:0] rd_val;
	logic [POS_W-1:0]               rd_pos;
	logic [POS_W:0]                 age_wide;
	logic [POS_W-1:0]               age;
	logic                           expired;
	logic                           dominated;
	logic                           push_go;

	assign head_next = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? LAST_SLOT : tail_q - 1'b1;
	assign pos_next  = (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;

	// A zero window behaves as one sample; anything past the queue depth is clamped.
	assign w_raw = CMP_W'(window_length_q);
	always_comb begin
		priority if (w_raw == '0) begin
			w_eff = CMP_W'(1);
		end else if (w_raw > W_LIMIT) begin
			w_eff = W_LIMIT;
		end else begin
			w_eff = w_raw;
		end
	end

	assign rd_val = $signed(ram_rdata[SAMPLE_WIDTH-1:0]);
	assign rd_pos = ram_rdata[RAM_W-1:SAMPLE_WIDTH];

	// Age of the head candidate, with positions counted modulo twice the depth.
	assign age_wide = (pos_q >= rd_pos) ? ({1'b0, pos_q} - {1'b0, rd_pos})
	                                    : ({1'b0, pos_q} + POS_MOD - {1'b0, rd_pos});
	assign age      = age_wide[POS_W-1:0];
	assign expired  = CMP_W'(age) >= w_eff;

	// Equal values stay in the queue.
	assign dominated = select_min_q ? (rd_val > sample_q) : (rd_val < sample_q);

	assign push_go   = (state_q == ST_PUSH) && (!out_valid_q || out_ready);
	assign ram_we    = push_go;
	assign ram_raddr = (state_q == ST_HEAD_RD) ? head_q : tail_prev;

	swmm_ram #(
		.WIDTH (RAM_W),
		.DEPTH (WINDOW_MAX)
	) u_queue_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata ({pos_q, sample_q}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			window_length_q <= CFG_W'(1);
			select_min_q    <= 1'b0;
			head_q          <= '0;
			tail_q          <= '0;
			count_q         <= '0;
			pos_q           <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !push_go) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				unique case (cfg_index)
					REG_WINDOW_LENGTH: begin
						window_length_q <= cfg_data;
					end
					REG_SELECT_MIN: begin
						// Switching mode invalidates every candidate.
						if (cfg_data[0] != select_min_q) begin
							head_q  <= '0;
							tail_q  <= '0;
							count_q <= '0;
						end
						select_min_q <= cfg_data[0];
					end
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (series_start) begin
							head_q  <= '0;
							tail_q  <= '0;
							count_q <= '0;
							pos_q   <= '0;
						end
						state_q <= ST_HEAD_RD;
					end
				end
				ST_HEAD_RD: begin
					state_q <= (count_q == '0) ? ST_TAIL_RD : ST_HEAD_CHK;
				end
				ST_HEAD_CHK: begin
					if (expired) begin
						head_q  <= head_next;
						count_q <= count_q - 1'b1;
						state_q <= ST_HEAD_RD;
					end else begin
						head_val_q <= rd_val;
						state_q    <= ST_TAIL_RD;
					end
				end
				ST_TAIL_RD: begin
					state_q <= (count_q == '0) ? ST_PUSH : ST_TAIL_CHK;
				end
				ST_TAIL_CHK: begin
					if (dominated) begin
						tail_q  <= tail_prev;
						count_q <= count_q - 1'b1;
						state_q <= ST_TAIL_RD;
					end else begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_go) begin
						// The head survives the tail scan unless the queue was emptied.
						extreme_q   <= (count_q == '0) ? sample_q : head_val_q;
						out_valid_q <= 1'b1;
						tail_q      <= tail_next;
						count_q     <= count_q + 1'b1;
						pos_q       <= pos_next;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			sample_q <= sample;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign extreme   = extreme_q;

endmodule
`default_nettype wire
